// ===== rtl/sle_pkg.sv =====
// Shared types and constants for the sequential list engine.
package sle_pkg;

   localparam int DEPTH = 64;
   localparam int AW = $clog2(DEPTH);
   localparam int CW = AW + 1;

   typedef enum logic [2:0] {
      OP_APPEND  = 3'd0,
      OP_INSERT  = 3'd1,
      OP_DELETE  = 3'd2,
      OP_SORT    = 3'd3,
      OP_REVERSE = 3'd4,
      OP_READ    = 3'd5,
      OP_FIND    = 3'd6,
      OP_NONE    = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_BADPOS   = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [6:0]  position;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] data_out;
      logic [6:0]  found_position;
      logic [6:0]  fill_count;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RD,
      S_WR,
      S_INSV,
      S_DGET,
      S_RDW,
      S_SRD,
      S_SRDW,
      S_SCMP,
      S_RV1,
      S_RV1W,
      S_RV2W,
      S_RV3,
      S_RESP
   } exec_state_type;

endpackage

// ===== rtl/sle_if.sv =====
// Valid/ready channel interfaces for requests and responses.
interface sle_req_if;
   logic             valid;
   logic             ready;
   sle_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface sle_rsp_if;
   logic             valid;
   logic             ready;
   sle_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/sle_queue.sv =====
// Two-entry request queue between the front end and the execution unit.
module sle_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  sle_pkg::req_type  in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output sle_pkg::req_type  out_data
);
   sle_pkg::req_type mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   // advance pointers and count
   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // store payload
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= in_data;
      end
   end
endmodule

// ===== rtl/sle_exec.sv =====
// Execution unit: list memory and sequencer that walks entries one at a time.
module sle_exec (
   input  logic              clock,
   input  logic              reset,
   input  logic [6:0]        capacity,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  sle_pkg::req_type  cmd,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sle_pkg::rsp_type  rsp
);
   localparam int AW = sle_pkg::AW;
   localparam int CW = sle_pkg::CW;

   logic [31:0]   mem [sle_pkg::DEPTH];
   logic [31:0]   rdata_ff;
   logic [AW-1:0] raddr;
   logic [AW-1:0] waddr;
   logic [31:0]   wdata;
   logic          we;

   sle_pkg::exec_state_type state_ff, state_in;
   sle_pkg::req_type        req_ff, req_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in, end_ff, end_in;
   logic [31:0]   t_ff, t_in, hold_ff, hold_in;
   sle_pkg::rsp_type  out_ff, out_in;

   logic [CW-1:0] pos_c, lim;
   logic full, pos_ok, empty, sort_shift;

   assign pos_c  = cmd.position[CW-1:0];
   assign lim    = (capacity < 7'(sle_pkg::DEPTH)) ? capacity[CW-1:0] : CW'(sle_pkg::DEPTH);
   assign full   = count_ff >= lim;
   assign empty  = count_ff == '0;
   assign pos_ok = (cmd.position != 7'd0) && (cmd.position <= 7'(count_ff));
   assign sort_shift = (j_ff != '0) && ($signed(t_ff) < $signed(rdata_ff));

   assign cmd_ready = (state_ff == sle_pkg::S_IDLE);
   assign rsp_valid = (state_ff == sle_pkg::S_RESP);
   assign rsp       = out_ff;

   // memory: one write and one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   // next state and datapath
   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      count_in = count_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      end_in   = end_ff;
      t_in     = t_ff;
      hold_in  = hold_ff;
      out_in   = out_ff;
      unique case (state_ff)
         sle_pkg::S_IDLE: begin
            if (cmd_valid) begin
               req_in = cmd;
               out_in = '0;
               out_in.status = sle_pkg::ST_OK;
               out_in.fill_count = 7'(count_ff);
               state_in = sle_pkg::S_RESP;
               unique case (sle_pkg::op_type'(cmd.op))
                  sle_pkg::OP_APPEND: begin
                     if (full) out_in.status = sle_pkg::ST_FULL;
                     else begin
                        count_in = count_ff + 1'b1;
                        out_in.fill_count = 7'(count_ff + 1'b1);
                     end
                  end
                  sle_pkg::OP_INSERT: begin
                     if (full) out_in.status = sle_pkg::ST_FULL;
                     else if (!pos_ok) out_in.status = sle_pkg::ST_BADPOS;
                     else begin
                        // move entries up from the top, then drop the word in
                        i_in   = count_ff;
                        end_in = pos_c;
                        state_in = sle_pkg::S_RD;
                        count_in = count_ff + 1'b1;
                        out_in.fill_count = 7'(count_ff + 1'b1);
                     end
                  end
                  sle_pkg::OP_DELETE: begin
                     if (empty) out_in.status = sle_pkg::ST_EMPTY;
                     else if (!pos_ok) out_in.status = sle_pkg::ST_BADPOS;
                     else begin
                        i_in   = pos_c - 1'b1;
                        end_in = count_ff - 1'b1;
                        state_in = sle_pkg::S_DGET;
                        count_in = count_ff - 1'b1;
                        out_in.fill_count = 7'(count_ff - 1'b1);
                     end
                  end
                  sle_pkg::OP_SORT: begin
                     if (empty) out_in.status = sle_pkg::ST_EMPTY;
                     else if (count_ff > CW'(1)) begin
                        i_in = CW'(1);
                        state_in = sle_pkg::S_SRD;
                     end
                  end
                  sle_pkg::OP_REVERSE: begin
                     if (empty) out_in.status = sle_pkg::ST_EMPTY;
                     else if (count_ff > CW'(1)) begin
                        i_in = '0;
                        j_in = count_ff - 1'b1;
                        state_in = sle_pkg::S_RV1;
                     end
                  end
                  sle_pkg::OP_READ: begin
                     if (!pos_ok) out_in.status = sle_pkg::ST_BADPOS;
                     else state_in = sle_pkg::S_RDW;
                  end
                  sle_pkg::OP_FIND: begin
                     i_in = '0;
                     if (empty) out_in.status = sle_pkg::ST_NOTFOUND;
                     else state_in = sle_pkg::S_RDW;
                  end
                  default: ;
               endcase
            end
         end
         // insert/delete shift: read source entry
         sle_pkg::S_RD: begin
            state_in = sle_pkg::S_WR;
         end
         // insert/delete shift: write it one slot over
         sle_pkg::S_WR: begin
            if (req_ff.op == sle_pkg::OP_INSERT) begin
               if (i_ff == end_ff) state_in = sle_pkg::S_INSV;
               else begin
                  i_in = i_ff - 1'b1;
                  state_in = sle_pkg::S_RD;
               end
            end else begin
               if (i_ff + 1'b1 == end_ff) state_in = sle_pkg::S_RESP;
               else begin
                  i_in = i_ff + 1'b1;
                  state_in = sle_pkg::S_RD;
               end
            end
         end
         // insert: write the new word into the opened slot
         sle_pkg::S_INSV: begin
            state_in = sle_pkg::S_RESP;
         end
         // delete: capture the removed word, then close the gap
         sle_pkg::S_DGET: begin
            out_in.data_out = rdata_ff;
            if (i_ff == end_ff) state_in = sle_pkg::S_RESP;
            else state_in = sle_pkg::S_RD;
         end
         // read and find: read data arrives in the cycle after its address
         sle_pkg::S_RDW: begin
            if (req_ff.op == sle_pkg::OP_READ) begin
               out_in.data_out = rdata_ff;
               state_in = sle_pkg::S_RESP;
            end else begin
               if (rdata_ff == req_ff.value) out_in.found_position = 7'(i_ff + 1'b1);
               if (i_ff + 1'b1 == count_ff) begin
                  if (rdata_ff != req_ff.value && out_ff.found_position == 7'd0)
                     out_in.status = sle_pkg::ST_NOTFOUND;
                  state_in = sle_pkg::S_RESP;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end
         end
         // insertion sort: fetch key entries[i]
         sle_pkg::S_SRD: begin
            state_in = sle_pkg::S_SRDW;
            j_in = i_ff;
         end
         sle_pkg::S_SRDW: begin
            t_in = rdata_ff;
            state_in = sle_pkg::S_SCMP;
         end
         // compare key with entries[j-1] arriving now
         sle_pkg::S_SCMP: begin
            if (sort_shift) begin
               j_in = j_ff - 1'b1;
            end else begin
               if (i_ff + 1'b1 == count_ff) state_in = sle_pkg::S_RESP;
               else begin
                  i_in = i_ff + 1'b1;
                  state_in = sle_pkg::S_SRD;
               end
            end
         end
         // reverse: fetch both ends, write them back swapped
         sle_pkg::S_RV1: begin
            state_in = sle_pkg::S_RV1W;
         end
         sle_pkg::S_RV1W: begin
            hold_in = rdata_ff;
            state_in = sle_pkg::S_RV2W;
         end
         sle_pkg::S_RV2W: begin
            state_in = sle_pkg::S_RV3;
         end
         sle_pkg::S_RV3: begin
            i_in = i_ff + 1'b1;
            j_in = j_ff - 1'b1;
            if (i_ff + 2'd2 >= j_ff) state_in = sle_pkg::S_RESP;
            else state_in = sle_pkg::S_RV1W;
         end
         sle_pkg::S_RESP: begin
            if (rsp_ready) state_in = sle_pkg::S_IDLE;
         end
         default: state_in = sle_pkg::S_IDLE;
      endcase
   end

   // memory port control
   always_comb begin
      raddr = '0;
      we    = 1'b0;
      waddr = '0;
      wdata = req_ff.value;
      unique case (state_ff)
         sle_pkg::S_IDLE: begin
            raddr = AW'(pos_c - 1'b1);
            if (cmd_valid && cmd.op == sle_pkg::OP_FIND) raddr = '0;
            if (cmd_valid && cmd.op == sle_pkg::OP_APPEND && !full) begin
               we = 1'b1;
               waddr = count_ff[AW-1:0];
               wdata = cmd.value;
            end
         end
         sle_pkg::S_RD: begin
            if (req_ff.op == sle_pkg::OP_INSERT) raddr = AW'(i_ff - 1'b1);
            else raddr = AW'(i_ff + 1'b1);
         end
         sle_pkg::S_WR: begin
            we = 1'b1;
            waddr = AW'(i_ff);
            wdata = rdata_ff;
         end
         sle_pkg::S_INSV: begin
            we = 1'b1;
            waddr = AW'(end_ff - 1'b1);
            wdata = req_ff.value;
         end
         sle_pkg::S_RDW: raddr = AW'(i_ff + 1'b1);
         sle_pkg::S_SRD: raddr = AW'(i_ff);
         sle_pkg::S_SRDW: raddr = AW'(i_ff - 1'b1);
         sle_pkg::S_SCMP: begin
            we = 1'b1;
            waddr = AW'(j_ff);
            if (sort_shift) begin
               wdata = rdata_ff;
               raddr = AW'(j_ff - 2'd2);
            end else begin
               wdata = t_ff;
            end
         end
         sle_pkg::S_RV1: raddr = AW'(i_ff);
         sle_pkg::S_RV1W: raddr = AW'(j_ff);
         sle_pkg::S_RV2W: begin
            we = 1'b1;
            waddr = AW'(i_ff);
            wdata = rdata_ff;
         end
         sle_pkg::S_RV3: begin
            we = 1'b1;
            waddr = AW'(j_ff);
            wdata = hold_ff;
            raddr = AW'(i_ff + 1'b1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sle_pkg::S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      req_ff  <= req_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      end_ff  <= end_in;
      t_ff    <= t_in;
      hold_ff <= hold_in;
      out_ff  <= out_in;
   end
endmodule

// ===== rtl/sequential_list_engine_core.sv =====
// Top level of the sequential list engine: front queue, execution unit, config.
// Usage:
//   Requests enter on the req channel (op, position, value) under valid/ready.
//   Each request yields exactly one response on the rsp channel carrying
//   status, data_out, found_position and fill_count, in request order.
//   Requests are buffered in a two-entry queue, so the sender may run ahead
//   while the execution unit works on an earlier transaction.
//   Find scans the list one entry at a time; insert and delete move the
//   entries one at a time; reverse swaps one pair at a time; sort handles
//   one key at a time and shifts up to n*n/2 entries in all. The list memory
//   does one read and one write per cycle. The execution unit holds one
//   transaction at a time and takes the next in the cycle after its
//   response is accepted.
//   csr_we with csr_wdata sets the capacity; write it only while idle.
//   Reset empties the list and sets capacity to 64; list memory is not
//   cleared, since data read from unfilled positions is never used.
//   A stalled response holds the execution unit; the queue then fills and
//   req_ready drops.
module sequential_list_engine_core (
   input  logic        clock,
   input  logic        reset,
   sle_req_if.sink     req,
   sle_rsp_if.source   rsp,
   input  logic        csr_we,
   input  logic [6:0]  csr_wdata
);
   logic [6:0] capacity_ff;
   logic       q_valid, q_ready;
   sle_pkg::req_type q_data;

   // hold capacity register
   always_ff @(posedge clock) begin
      if (reset) capacity_ff <= 7'd64;
      else if (csr_we) capacity_ff <= csr_wdata;
   end

   sle_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready), .in_data(req.payload),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
   );

   sle_exec u_exec (
      .clock(clock), .reset(reset), .capacity(capacity_ff),
      .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_data),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp(rsp.payload)
   );
endmodule

// ===== dv/tb_sequential_list_engine_core.sv =====
// Testbench for the sequential list engine: list predictor, random traffic, response check.
module tb_sequential_list_engine_core;
   timeunit 1ns;
   timeprecision 1ps;

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic [6:0] csr_wdata;

   sle_req_if req_ch ();
   sle_rsp_if rsp_ch ();

   sequential_list_engine_core dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch.sink),
      .rsp       (rsp_ch.source),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Predicted list contents and settings
   logic [31:0]      list_words [sle_pkg::DEPTH];
   int               list_fill;
   int               list_capacity;
   sle_pkg::rsp_type rsp_expected [$];
   int               mismatch_count;
   int               rsp_stall_mode;

   // Generate the clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // End the run if it hangs
   initial begin
      #40ms;
      $display("** sequential_list_engine_core: FAILED **");
      $finish;
   end

   function automatic bit list_is_full();
      int lim;
      lim = (list_capacity < sle_pkg::DEPTH) ? list_capacity : sle_pkg::DEPTH;
      return list_fill >= lim;
   endfunction

   // Apply one transaction to the predicted list and return its response
   function automatic sle_pkg::rsp_type apply_list_op(sle_pkg::req_type r);
      sle_pkg::rsp_type res;
      int               p;
      bit               pos_ok;
      logic [31:0]      t;
      int               j;
      p = r.position;
      pos_ok = (p >= 1) && (p <= list_fill);
      res = '0;
      res.status = sle_pkg::ST_OK;
      case (sle_pkg::op_type'(r.op))
         sle_pkg::OP_APPEND: begin
            if (list_is_full()) res.status = sle_pkg::ST_FULL;
            else begin
               list_words[list_fill] = r.value;
               list_fill++;
            end
         end
         sle_pkg::OP_INSERT: begin
            if (list_is_full()) res.status = sle_pkg::ST_FULL;
            else if (!pos_ok) res.status = sle_pkg::ST_BADPOS;
            else begin
               for (int i = list_fill; i >= p; i--) list_words[i] = list_words[i-1];
               list_words[p-1] = r.value;
               list_fill++;
            end
         end
         sle_pkg::OP_DELETE: begin
            if (list_fill == 0) res.status = sle_pkg::ST_EMPTY;
            else if (!pos_ok) res.status = sle_pkg::ST_BADPOS;
            else begin
               res.data_out = list_words[p-1];
               for (int i = p - 1; i + 1 < list_fill; i++) list_words[i] = list_words[i+1];
               list_fill--;
            end
         end
         sle_pkg::OP_SORT: begin
            if (list_fill == 0) res.status = sle_pkg::ST_EMPTY;
            else begin
               for (int i = 1; i < list_fill; i++) begin
                  t = list_words[i];
                  j = i;
                  while (j > 0 && $signed(t) < $signed(list_words[j-1])) begin
                     list_words[j] = list_words[j-1];
                     j--;
                  end
                  list_words[j] = t;
               end
            end
         end
         sle_pkg::OP_REVERSE: begin
            if (list_fill == 0) res.status = sle_pkg::ST_EMPTY;
            else begin
               for (int i = 0; i < list_fill / 2; i++) begin
                  t = list_words[i];
                  list_words[i] = list_words[list_fill-1-i];
                  list_words[list_fill-1-i] = t;
               end
            end
         end
         sle_pkg::OP_READ: begin
            if (!pos_ok) res.status = sle_pkg::ST_BADPOS;
            else res.data_out = list_words[p-1];
         end
         sle_pkg::OP_FIND: begin
            for (int i = 0; i < list_fill; i++)
               if (list_words[i] == r.value) res.found_position = 7'(i + 1);
            if (res.found_position == 0) res.status = sle_pkg::ST_NOTFOUND;
         end
         default: ;
      endcase
      res.fill_count = 7'(list_fill);
      return res;
   endfunction

   // Drive one transaction, with a random gap in front of some
   task automatic send_list_op(sle_pkg::op_type op, int position, logic [31:0] value);
      sle_pkg::req_type r;
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 6)) @(negedge clock) req_ch.valid <= 1'b0;
      r.op = op;
      r.position = 7'(position);
      r.value = value;
      @(negedge clock);
      req_ch.valid   <= 1'b1;
      req_ch.payload <= r;
      do @(posedge clock); while (!req_ch.ready);
      rsp_expected.push_back(apply_list_op(r));
      @(negedge clock);
      req_ch.valid <= 1'b0;
   endtask

   // Wait for every response, then let the engine settle
   task automatic drain_responses();
      while (rsp_expected.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_capacity(int cap);
      drain_responses();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= 7'(cap);
      @(negedge clock);
      csr_we <= 1'b0;
      list_capacity = cap;
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return 32'(int'($urandom_range(0, 7)) - 3);
         default: return $urandom;
      endcase
   endfunction

   // Pick a position, mostly inside the list, sometimes anywhere in 0 to 127
   function automatic int pick_position();
      if (list_fill > 0 && $urandom_range(0, 7) != 0) return $urandom_range(1, list_fill);
      return $urandom_range(0, 127);
   endfunction

   // Receiver stall pattern: no stalls, light, or heavy, changing over time
   always @(negedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else begin
         if ($urandom_range(0, 63) == 0) rsp_stall_mode = $urandom_range(0, 2);
         case (rsp_stall_mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Compare each response with the oldest prediction
   always @(posedge clock) begin
      sle_pkg::rsp_type want;
      sle_pkg::rsp_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.payload;
         if (rsp_expected.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected response %p", got);
         end else begin
            want = rsp_expected.pop_front();
            if (got.status !== want.status || got.data_out !== want.data_out ||
                got.found_position !== want.found_position ||
                got.fill_count !== want.fill_count) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("response mismatch: expected %p, got %p", want, got);
            end
         end
      end
   end

   // Directed: empty list cases, extremes, every operation
   task automatic test_directed();
      send_list_op(sle_pkg::OP_DELETE, 1, '0);
      send_list_op(sle_pkg::OP_SORT, 0, '0);
      send_list_op(sle_pkg::OP_REVERSE, 0, '0);
      send_list_op(sle_pkg::OP_READ, 1, '0);
      send_list_op(sle_pkg::OP_FIND, 0, 32'h0);
      send_list_op(sle_pkg::OP_INSERT, 1, 32'h5);
      send_list_op(sle_pkg::OP_APPEND, 0, 32'h7FFF_FFFF);
      send_list_op(sle_pkg::OP_APPEND, 127, 32'h8000_0000);
      send_list_op(sle_pkg::OP_APPEND, 0, 32'hFFFF_FFFF);
      send_list_op(sle_pkg::OP_INSERT, 1, 32'h0);
      send_list_op(sle_pkg::OP_INSERT, 4, 32'h7FFF_FFFF);
      send_list_op(sle_pkg::OP_INSERT, 6, 32'h1);
      send_list_op(sle_pkg::OP_FIND, 0, 32'h7FFF_FFFF);
      send_list_op(sle_pkg::OP_FIND, 0, 32'h1234_5678);
      send_list_op(sle_pkg::OP_SORT, 0, '0);
      send_list_op(sle_pkg::OP_REVERSE, 0, '0);
      send_list_op(sle_pkg::OP_READ, 5, '0);
      send_list_op(sle_pkg::OP_READ, 6, '0);
      send_list_op(sle_pkg::OP_READ, 0, '0);
      send_list_op(sle_pkg::OP_DELETE, 2, '0);
      send_list_op(sle_pkg::OP_DELETE, 64, '0);
      send_list_op(sle_pkg::OP_NONE, 127, 32'hFFFF_FFFF);
   endtask

   // Capacity extremes: zero, one, low below fill, and 127 above the depth
   task automatic test_capacity();
      write_capacity(0);
      send_list_op(sle_pkg::OP_APPEND, 0, 32'h9);
      send_list_op(sle_pkg::OP_INSERT, 1, 32'h9);
      write_capacity(1);
      send_list_op(sle_pkg::OP_APPEND, 0, 32'h9);
      while (list_fill > 0) send_list_op(sle_pkg::OP_DELETE, 1, '0);
      send_list_op(sle_pkg::OP_APPEND, 0, 32'h3);
      send_list_op(sle_pkg::OP_APPEND, 0, 32'h4);
      send_list_op(sle_pkg::OP_READ, 1, '0);
      write_capacity(127);
   endtask

   // Random: mixed traffic at the given capacity
   task automatic test_random(int cap, int count);
      int              k;
      sle_pkg::op_type op;
      write_capacity(cap);
      for (int n = 0; n < count; n++) begin
         k = $urandom_range(0, 99);
         if (k < 30) op = sle_pkg::OP_APPEND;
         else if (k < 45) op = sle_pkg::OP_INSERT;
         else if (k < 62) op = sle_pkg::OP_DELETE;
         else if (k < 67) op = sle_pkg::OP_SORT;
         else if (k < 72) op = sle_pkg::OP_REVERSE;
         else if (k < 84) op = sle_pkg::OP_READ;
         else if (k < 98) op = sle_pkg::OP_FIND;
         else op = sle_pkg::OP_NONE;
         if (op == sle_pkg::OP_FIND && list_fill > 0 && $urandom_range(0, 1))
            send_list_op(op, $urandom_range(0, 127), list_words[$urandom_range(0, list_fill-1)]);
         else send_list_op(op, pick_position(), pick_value());
      end
   endtask

   // Fill the whole list, try to overfill it, sort and reverse it full, then trim it
   task automatic test_full_list();
      write_capacity(64);
      while (!list_is_full()) send_list_op(sle_pkg::OP_APPEND, 0, pick_value());
      send_list_op(sle_pkg::OP_APPEND, 0, 32'h1);
      send_list_op(sle_pkg::OP_INSERT, 64, 32'h1);
      send_list_op(sle_pkg::OP_SORT, 0, '0);
      send_list_op(sle_pkg::OP_REVERSE, 0, '0);
      send_list_op(sle_pkg::OP_READ, 64, '0);
      send_list_op(sle_pkg::OP_DELETE, 64, '0);
      send_list_op(sle_pkg::OP_INSERT, 63, 32'h2);
      send_list_op(sle_pkg::OP_DELETE, 1, '0);
      send_list_op(sle_pkg::OP_FIND, 0, list_words[0]);
      while (list_fill > 8) send_list_op(sle_pkg::OP_DELETE, pick_position(), '0);
   endtask

   initial begin
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_wdata      = '0;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready   = 1'b0;
      rsp_stall_mode = 0;
      mismatch_count = 0;
      list_fill      = 0;
      list_capacity  = 64;
      repeat (10) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      test_directed();
      test_capacity();
      test_random(12, 130);
      test_random(3, 60);
      test_full_list();
      test_random(64, 60);
      test_random(100, 60);
      drain_responses();

      if (mismatch_count == 0) $display("** sequential_list_engine_core: PASSED **");
      else $display("** sequential_list_engine_core: FAILED **");
      $finish;
   end
endmodule
